// ===== rtl/qmj_pkg.sv =====
// shared constants, types and structs for the quintic min-jerk coefficient unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qmj_pkg;

  localparam int IN_W      = 32;
  localparam int DUR_W     = 24;
  localparam int COEF_W    = 64;
  localparam int LIN_W     = 88;
  localparam int NUM_W     = 152;
  localparam int DEN_W     = 120;
  localparam int DIV_STEPS = 65;
  localparam int DIV_LAT   = DIV_STEPS + 3;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // coefficients that bypass the dividers
  typedef struct packed {
    coef_t c0;
    coef_t c1;
    coef_t c2;
    logic  singular;
  } side_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic        [DEN_W-1:0] den;
  } div_req_t;

endpackage

`default_nettype wire

// ===== rtl/qmj_if.sv =====
// valid/ready channel interfaces for request and coefficient words
// depends on qmj_pkg
`timescale 1ns / 1ps
`default_nettype none

interface qmj_in_if import qmj_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  start_position;
  logic signed [IN_W-1:0]  start_velocity;
  logic signed [IN_W-1:0]  start_accel;
  logic signed [IN_W-1:0]  end_position;
  logic signed [IN_W-1:0]  end_velocity;
  logic signed [IN_W-1:0]  end_accel;
  logic        [DUR_W-1:0] duration;

  modport source (
    output valid, start_position, start_velocity, start_accel,
    output end_position, end_velocity, end_accel, duration,
    input  ready
  );
  modport sink (
    input  valid, start_position, start_velocity, start_accel,
    input  end_position, end_velocity, end_accel, duration,
    output ready
  );
endinterface

interface qmj_out_if import qmj_pkg::*;;
  logic  valid;
  logic  ready;
  coef_t coef_zero;
  coef_t coef_one;
  coef_t coef_two;
  coef_t coef_three;
  coef_t coef_four;
  coef_t coef_five;
  logic  singular;
  logic  overflow;

  modport source (
    output valid, coef_zero, coef_one, coef_two, coef_three, coef_four, coef_five,
    output singular, overflow,
    input  ready
  );
  modport sink (
    input  valid, coef_zero, coef_one, coef_two, coef_three, coef_four, coef_five,
    input  singular, overflow,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/qmj_prep.sv =====
// eight-stage front end: boundary terms, powers of the duration and the
// scaled numerators for the three divisions; depends on qmj_pkg
`timescale 1ns / 1ps
`default_nettype none

module qmj_prep import qmj_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [IN_W-1:0]  start_position,
  input  logic signed [IN_W-1:0]  start_velocity,
  input  logic signed [IN_W-1:0]  start_accel,
  input  logic signed [IN_W-1:0]  end_position,
  input  logic signed [IN_W-1:0]  end_velocity,
  input  logic signed [IN_W-1:0]  end_accel,
  input  logic        [DUR_W-1:0] duration,
  output logic                    out_valid,
  output side_t                   out_side,
  output div_req_t                req3,
  output div_req_t                req4,
  output div_req_t                req5
);

  logic [7:0] v_r;
  side_t      side_r [8];
  side_t      side_nxt;

  // stage 0
  logic signed [31:0] s0_vs_r, s0_as_r;
  logic signed [32:0] s0_dpos_r, s0_dvel_r, s0_dacc_r;
  logic signed [32:0] dpos_nxt, dvel_nxt, dacc_nxt;
  logic [23:0]        s0_d_r;
  // stage 1
  logic signed [24:0] dsg0;
  logic signed [56:0] s1_vd_r, s1_ad_r, vd_nxt, ad_nxt;
  logic signed [57:0] s1_dad_r, dad_nxt;
  logic [47:0]        s1_d2_r, d2_nxt;
  logic signed [32:0] s1_dpos_r, s1_dvel_r;
  logic [23:0]        s1_d_r;
  // stage 2
  logic signed [24:0] dsg1;
  logic signed [57:0] s2_dv_r, dv_nxt;
  logic signed [74:0] s2_ha_r, ha_nxt;
  logic [51:0]        s2_ad_lo_r, s2_dad_lo_r, ad_lo_nxt, dad_lo_nxt;
  logic signed [53:0] s2_ad_hi_r, ad_hi_nxt;
  logic signed [54:0] s2_dad_hi_r, dad_hi_nxt;
  logic [47:0]        s2_d2_lo_r, s2_d2_hi_r, d2_lo_nxt, d2_hi_nxt;
  logic [23:0]        s2_d_r;
  // stage 3
  logic signed [24:0] dsg2;
  logic signed [81:0] s3_add_r, add_nxt;
  logic signed [82:0] s3_y_r, y_nxt;
  logic [71:0]        s3_d3_r, d3_nxt;
  logic [51:0]        s3_x_lo_r, x_lo_nxt;
  logic signed [54:0] s3_x_hi_r, x_hi_nxt;
  logic signed [74:0] s3_ha_r;
  logic [23:0]        s3_d_r;
  // stage 4
  logic signed [82:0] s4_x_r, s4_h_r, s4_y_r, x_nxt, h_nxt;
  logic [47:0]        s4_p0_r, s4_p1_r, s4_p2_r, p0_nxt, p1_nxt, p2_nxt;
  logic [71:0]        s4_d3_r;
  logic [23:0]        s4_d_r;
  // stage 5
  logic signed [LIN_W-1:0] hw, xw, yw;
  logic signed [LIN_W-1:0] s5_n3_r, s5_n4_r, s5_n5_r, n3_nxt, n4_nxt, n5_nxt;
  logic [95:0]        s5_d4_r, d4_nxt;
  logic [71:0]        s5_d3_r;
  logic [23:0]        s5_d_r;
  // stage 6
  logic [47:0]        s6_q_r [4];
  logic [47:0]        q_nxt [4];
  logic signed [LIN_W-1:0] s6_n3_r, s6_n4_r, s6_n5_r;
  logic [95:0]        s6_d4_r;
  logic [71:0]        s6_d3_r;
  // stage 7
  logic [DEN_W-1:0]   s7_d5_r, d5_nxt;
  logic signed [LIN_W-1:0] s7_n3_r, s7_n4_r, s7_n5_r;
  logic [95:0]        s7_d4_r;
  logic [71:0]        s7_d3_r;

  always_comb begin
    side_nxt.singular = (duration == '0);
    side_nxt.c0 = side_nxt.singular ? '0 : {{16{start_position[31]}}, start_position, 16'b0};
    side_nxt.c1 = side_nxt.singular ? '0 : {{16{start_velocity[31]}}, start_velocity, 16'b0};
    side_nxt.c2 = side_nxt.singular ? '0 : {{17{start_accel[31]}}, start_accel, 15'b0};
    dpos_nxt = 33'(end_position) - 33'(start_position);
    dvel_nxt = 33'(end_velocity) - 33'(start_velocity);
    dacc_nxt = 33'(end_accel) - 33'(start_accel);

    dsg0    = $signed({1'b0, s0_d_r});
    vd_nxt  = 57'(s0_vs_r) * 57'(dsg0);
    ad_nxt  = 57'(s0_as_r) * 57'(dsg0);
    dad_nxt = 58'(s0_dacc_r) * 58'(dsg0);
    d2_nxt  = 48'(s0_d_r) * 48'(s0_d_r);

    dsg1       = $signed({1'b0, s1_d_r});
    dv_nxt     = {{9{s1_dvel_r[32]}}, s1_dvel_r, 16'b0} - 58'(s1_ad_r);
    ha_nxt     = {{9{s1_dpos_r[32]}}, s1_dpos_r, 33'b0} - {s1_vd_r[56], s1_vd_r, 17'b0};
    ad_lo_nxt  = 52'(s1_ad_r[27:0]) * 52'(s1_d_r);
    ad_hi_nxt  = 54'($signed(s1_ad_r[56:28])) * 54'(dsg1);
    dad_lo_nxt = 52'(s1_dad_r[27:0]) * 52'(s1_d_r);
    dad_hi_nxt = 55'($signed(s1_dad_r[57:28])) * 55'(dsg1);
    d2_lo_nxt  = 48'(s1_d2_r[23:0]) * 48'(s1_d_r);
    d2_hi_nxt  = 48'(s1_d2_r[47:24]) * 48'(s1_d_r);

    dsg2     = $signed({1'b0, s2_d_r});
    add_nxt  = (82'(s2_ad_hi_r) <<< 28) + 82'(s2_ad_lo_r);
    y_nxt    = (83'(s2_dad_hi_r) <<< 28) + 83'(s2_dad_lo_r);
    d3_nxt   = {s2_d2_hi_r, 24'b0} + 72'(s2_d2_lo_r);
    x_lo_nxt = 52'(s2_dv_r[27:0]) * 52'(s2_d_r);
    x_hi_nxt = 55'($signed(s2_dv_r[57:28])) * 55'(dsg2);

    x_nxt  = (83'(s3_x_hi_r) <<< 28) + 83'(s3_x_lo_r);
    h_nxt  = 83'(s3_ha_r) - 83'(s3_add_r);
    p0_nxt = 48'(s3_d3_r[23:0]) * 48'(s3_d_r);
    p1_nxt = 48'(s3_d3_r[47:24]) * 48'(s3_d_r);
    p2_nxt = 48'(s3_d3_r[71:48]) * 48'(s3_d_r);

    // numerators of c3, c4, c5 as shift-add combinations
    hw     = LIN_W'(s4_h_r);
    xw     = LIN_W'(s4_x_r);
    yw     = LIN_W'(s4_y_r);
    n3_nxt = (hw <<< 3) + (hw <<< 1) - (xw <<< 3) + yw;
    n4_nxt = hw - (hw <<< 4) + (xw <<< 4) - (xw <<< 1) - (yw <<< 1);
    n5_nxt = (hw <<< 2) + (hw <<< 1) - (xw <<< 2) - (xw <<< 1) + yw;
    d4_nxt = {s4_p2_r, 48'b0} + {24'b0, s4_p1_r, 24'b0} + 96'(s4_p0_r);

    for (int k = 0; k < 4; k++) begin
      q_nxt[k] = 48'(s5_d4_r[24*k +: 24]) * 48'(s5_d_r);
    end

    d5_nxt = {s6_q_r[3], 72'b0} + {24'b0, s6_q_r[2], 48'b0} + {48'b0, s6_q_r[1], 24'b0}
           + DEN_W'(s6_q_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < 8; k++) begin
        side_r[k] <= side_r[k-1];
      end
      s0_vs_r   <= start_velocity;
      s0_as_r   <= start_accel;
      s0_dpos_r <= dpos_nxt;
      s0_dvel_r <= dvel_nxt;
      s0_dacc_r <= dacc_nxt;
      s0_d_r    <= duration;

      s1_vd_r   <= vd_nxt;
      s1_ad_r   <= ad_nxt;
      s1_dad_r  <= dad_nxt;
      s1_d2_r   <= d2_nxt;
      s1_dpos_r <= s0_dpos_r;
      s1_dvel_r <= s0_dvel_r;
      s1_d_r    <= s0_d_r;

      s2_dv_r     <= dv_nxt;
      s2_ha_r     <= ha_nxt;
      s2_ad_lo_r  <= ad_lo_nxt;
      s2_ad_hi_r  <= ad_hi_nxt;
      s2_dad_lo_r <= dad_lo_nxt;
      s2_dad_hi_r <= dad_hi_nxt;
      s2_d2_lo_r  <= d2_lo_nxt;
      s2_d2_hi_r  <= d2_hi_nxt;
      s2_d_r      <= s1_d_r;

      s3_add_r  <= add_nxt;
      s3_y_r    <= y_nxt;
      s3_d3_r   <= d3_nxt;
      s3_x_lo_r <= x_lo_nxt;
      s3_x_hi_r <= x_hi_nxt;
      s3_ha_r   <= s2_ha_r;
      s3_d_r    <= s2_d_r;

      s4_x_r  <= x_nxt;
      s4_h_r  <= h_nxt;
      s4_y_r  <= s3_y_r;
      s4_p0_r <= p0_nxt;
      s4_p1_r <= p1_nxt;
      s4_p2_r <= p2_nxt;
      s4_d3_r <= s3_d3_r;
      s4_d_r  <= s3_d_r;

      s5_n3_r <= n3_nxt;
      s5_n4_r <= n4_nxt;
      s5_n5_r <= n5_nxt;
      s5_d4_r <= d4_nxt;
      s5_d3_r <= s4_d3_r;
      s5_d_r  <= s4_d_r;

      for (int k = 0; k < 4; k++) begin
        s6_q_r[k] <= q_nxt[k];
      end
      s6_n3_r <= s5_n3_r;
      s6_n4_r <= s5_n4_r;
      s6_n5_r <= s5_n5_r;
      s6_d4_r <= s5_d4_r;
      s6_d3_r <= s5_d3_r;

      s7_d5_r <= d5_nxt;
      s7_n3_r <= s6_n3_r;
      s7_n4_r <= s6_n4_r;
      s7_n5_r <= s6_n5_r;
      s7_d4_r <= s6_d4_r;
      s7_d3_r <= s6_d3_r;
    end
  end

  assign out_valid = v_r[7];
  assign out_side  = side_r[7];
  assign req3.num  = {{33{s7_n3_r[LIN_W-1]}}, s7_n3_r, 31'b0};
  assign req3.den  = DEN_W'(s7_d3_r);
  assign req4.num  = {{17{s7_n4_r[LIN_W-1]}}, s7_n4_r, 47'b0};
  assign req4.den  = DEN_W'(s7_d4_r);
  assign req5.num  = {s7_n5_r[LIN_W-1], s7_n5_r, 63'b0};
  assign req5.den  = s7_d5_r;

endmodule

`default_nettype wire

// ===== rtl/qmj_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with
// round to nearest and saturation to a signed Q31.32 word; depends on qmj_pkg
`timescale 1ns / 1ps
`default_nettype none

module qmj_div import qmj_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  div_req_t req,
  output coef_t    quo,
  output logic     ovf
);

  logic             neg_a_r;
  logic [NUM_W-1:0] mag_a_r, mag_nxt;
  logic [DEN_W-1:0] den_a_r;

  logic [DEN_W-1:0]     rem_r [DIV_STEPS];
  logic [DEN_W-1:0]     rem_nxt [DIV_STEPS];
  logic [DIV_STEPS-1:0] mq_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] mq_nxt [DIV_STEPS];
  logic [DEN_W-1:0]     dd_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] neg_r, high_r;
  logic                 high_nxt;

  logic [DEN_W-1:0]     rin, din;
  logic [DIV_STEPS-1:0] qin;
  logic [DEN_W:0]       trial, diff;
  logic                 ge;

  logic                 rnd;
  logic [DIV_STEPS:0]   q1_r, q1_nxt, lim;
  logic                 neg_f_r, high_f_r, sat;
  coef_t                quo_r, quo_nxt;
  logic                 ovf_r;

  always_comb begin
    mag_nxt  = req.num[NUM_W-1] ? (~req.num + 1'b1) : req.num;
    // quotient too wide for the word
    high_nxt = DEN_W'(mag_a_r[NUM_W-1:DIV_STEPS]) >= den_a_r;
    rin   = '0;
    din   = '0;
    qin   = '0;
    trial = '0;
    diff  = '0;
    ge    = 1'b0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (i == 0) begin
        rin = DEN_W'(mag_a_r[NUM_W-1:DIV_STEPS]);
        qin = mag_a_r[DIV_STEPS-1:0];
        din = den_a_r;
      end else begin
        rin = rem_r[i-1];
        qin = mq_r[i-1];
        din = dd_r[i-1];
      end
      trial      = {rin, qin[DIV_STEPS-1]};
      diff       = trial - {1'b0, din};
      ge         = trial >= {1'b0, din};
      rem_nxt[i] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      mq_nxt[i]  = {qin[DIV_STEPS-2:0], ge};
    end

    rnd    = {rem_r[DIV_STEPS-1], 1'b0} >= {1'b0, dd_r[DIV_STEPS-1]};
    q1_nxt = {1'b0, mq_r[DIV_STEPS-1]} + (DIV_STEPS+1)'(rnd);

    lim     = neg_f_r ? {2'b0, 1'b1, 63'b0} : {3'b0, {63{1'b1}}};
    sat     = high_f_r || (q1_r > lim);
    quo_nxt = sat ? (neg_f_r ? COEF_MIN : COEF_MAX)
                  : (neg_f_r ? (~q1_r[COEF_W-1:0] + 64'd1) : q1_r[COEF_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r <= req.num[NUM_W-1];
      mag_a_r <= mag_nxt;
      den_a_r <= req.den;

      for (int i = 0; i < DIV_STEPS; i++) begin
        rem_r[i] <= rem_nxt[i];
        mq_r[i]  <= mq_nxt[i];
      end
      dd_r[0]   <= den_a_r;
      neg_r[0]  <= neg_a_r;
      high_r[0] <= high_nxt;
      for (int i = 1; i < DIV_STEPS; i++) begin
        dd_r[i]   <= dd_r[i-1];
        neg_r[i]  <= neg_r[i-1];
        high_r[i] <= high_r[i-1];
      end

      q1_r     <= q1_nxt;
      neg_f_r  <= neg_r[DIV_STEPS-1];
      high_f_r <= high_r[DIV_STEPS-1];

      quo_r <= quo_nxt;
      ovf_r <= sat;
    end
  end

  assign quo = quo_r;
  assign ovf = ovf_r;

endmodule

`default_nettype wire

// ===== rtl/quintic_min_jerk_coefficients_unit.sv =====
// top level of the quintic min-jerk coefficient unit
// depends on qmj_pkg, qmj_if, qmj_prep and qmj_div
`timescale 1ns / 1ps
`default_nettype none

// Takes one request word per clock and returns the six coefficients of the
// minimum-jerk quintic: the front end forms the scaled numerators and
// T^3, T^4, T^5, then three parallel pipelined dividers resolve one
// quotient bit per stage. The whole pipeline advances together; while a
// finished word waits on out_word.ready the pipeline holds and
// in_word.ready is low.

module quintic_min_jerk_coefficients_unit import qmj_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  qmj_in_if.sink        in_word,
  qmj_out_if.source     out_word
);

  logic     en;
  logic     prep_valid;
  side_t    prep_side;
  div_req_t req3, req4, req5;
  coef_t    q3, q4, q5;
  logic     o3, o4, o5;

  logic [DIV_LAT-1:0] vld_r;
  side_t              side_d_r [DIV_LAT];
  side_t              sd;

  assign en            = !vld_r[DIV_LAT-1] || out_word.ready;
  assign in_word.ready = en;

  qmj_prep u_prep (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_word.valid),
    .start_position (in_word.start_position),
    .start_velocity (in_word.start_velocity),
    .start_accel    (in_word.start_accel),
    .end_position   (in_word.end_position),
    .end_velocity   (in_word.end_velocity),
    .end_accel      (in_word.end_accel),
    .duration       (in_word.duration),
    .out_valid      (prep_valid),
    .out_side       (prep_side),
    .req3           (req3),
    .req4           (req4),
    .req5           (req5)
  );

  qmj_div u_div3 (.clk(clk), .en(en), .req(req3), .quo(q3), .ovf(o3));
  qmj_div u_div4 (.clk(clk), .en(en), .req(req4), .quo(q4), .ovf(o4));
  qmj_div u_div5 (.clk(clk), .en(en), .req(req5), .quo(q5), .ovf(o5));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_LAT-2:0], prep_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r[0] <= prep_side;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_d_r[i] <= side_d_r[i-1];
      end
    end
  end

  assign sd                  = side_d_r[DIV_LAT-1];
  assign out_word.valid      = vld_r[DIV_LAT-1];
  assign out_word.coef_zero  = sd.c0;
  assign out_word.coef_one   = sd.c1;
  assign out_word.coef_two   = sd.c2;
  assign out_word.coef_three = sd.singular ? '0 : q3;
  assign out_word.coef_four  = sd.singular ? '0 : q4;
  assign out_word.coef_five  = sd.singular ? '0 : q5;
  assign out_word.singular   = sd.singular;
  assign out_word.overflow   = !sd.singular && (o3 || o4 || o5);

  // overflow only with a saturated coefficient
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.overflow |->
      out_word.coef_three == COEF_MAX || out_word.coef_three == COEF_MIN ||
      out_word.coef_four == COEF_MAX || out_word.coef_four == COEF_MIN ||
      out_word.coef_five == COEF_MAX || out_word.coef_five == COEF_MIN)
    else $error("overflow without saturated coefficient");

  // a held pipeline keeps coef_three, coef_five and the overflow flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_word.coef_three) && $stable(out_word.coef_five) &&
            $stable(out_word.overflow))
    else $error("divider output moved during stall");

  // zero duration word carries no overflow and zero terms
  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.singular |->
      !out_word.overflow && out_word.coef_zero == '0 && out_word.coef_two == '0)
    else $error("singular word not cleared");

endmodule

`default_nettype wire
